FILE: sv/kms_pkg.sv
// shared types, constants and key map for the keypad scanner
`timescale 1ns / 1ps

package kms_pkg;

    // key and row geometry
    localparam int KEY_COUNT   = 11;
    localparam int KEY_W       = 4;
    localparam int ROW_W       = 2;
    localparam int COL_COUNT   = 3;
    localparam int STACK_DEPTH = 16;

    // operation selector codes
    localparam logic [1:0] FUNC_SCAN  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // single-key decode status codes
    localparam logic [1:0] ST_ONE  = 2'd0;
    localparam logic [1:0] ST_MANY = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef logic [KEY_W-1:0] t_key;

    // map entry: key index plus a flag for a populated position
    typedef struct packed {
        logic vld;
        t_key key;
    } t_map_ent;

    // command from the scan logic to the release stack
    typedef struct packed {
        logic                     en;
        logic                     pop;
        logic                     clear;
        logic [COL_COUNT-1:0]     push_vld;
        t_key [COL_COUNT-1:0]     push_key;
    } t_stack_cmd;

    // fixed key map, column bit to key for each row; row 3 column 0 is unused
    function automatic t_map_ent key_at(input logic [ROW_W-1:0] row, input logic [1:0] col);
        t_map_ent e;
        e.vld = 1'b1;
        e.key = '0;
        case ({row, col})
            4'b00_00: e.key = t_key'(7);
            4'b00_01: e.key = t_key'(9);
            4'b00_10: e.key = t_key'(8);
            4'b01_00: e.key = t_key'(4);
            4'b01_01: e.key = t_key'(6);
            4'b01_10: e.key = t_key'(5);
            4'b10_00: e.key = t_key'(1);
            4'b10_01: e.key = t_key'(3);
            4'b10_10: e.key = t_key'(2);
            4'b11_01: e.key = t_key'(10);
            4'b11_10: e.key = t_key'(0);
            default:  e.vld = 1'b0;
        endcase
        return e;
    endfunction

endpackage

FILE: sv/kms_stack.sv
// bounded release stack, newest entry held at position zero, oldest drops off the far end
`timescale 1ns / 1ps

module kms_stack import kms_pkg::*; #(
    parameter int DEPTH = STACK_DEPTH,
    parameter int FW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stack_cmd    i_cmd,
    output logic          o_pop_valid,
    output t_key          o_pop_key,
    output logic [FW-1:0] o_fill_next
);

    t_key [DEPTH-1:0] r_ent;
    t_key [DEPTH-1:0] n_ent;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;

    // next stack contents for clear, pop, or up to three pushes in order
    always_comb begin
        n_ent       = r_ent;
        n_fill      = r_fill;
        o_pop_valid = 1'b0;
        o_pop_key   = '0;
        if (i_cmd.clear) begin
            n_fill = '0;
        end else if (i_cmd.pop) begin
            if (r_fill != '0) begin
                o_pop_valid = 1'b1;
                o_pop_key   = r_ent[0];
                for (int i = 0; i < DEPTH - 1; i++) begin
                    n_ent[i] = r_ent[i+1];
                end
                n_fill = r_fill - FW'(1);
            end
        end else begin
            for (int j = 0; j < COL_COUNT; j++) begin
                if (i_cmd.push_vld[j]) begin
                    for (int i = DEPTH - 1; i >= 1; i--) begin
                        n_ent[i] = n_ent[i-1];
                    end
                    n_ent[0] = i_cmd.push_key[j];
                    if (n_fill != FW'(DEPTH)) begin
                        n_fill = n_fill + FW'(1);
                    end
                end
            end
        end
    end

    assign o_fill_next = i_cmd.en ? n_fill : r_fill;

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.en) begin
            r_fill <= n_fill;
        end
    end

    // entries, undefined until written
    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_ent <= n_ent;
        end
    end

endmodule

FILE: sv/keypad_matrix_scanner_with_event_stack.sv
// top level: keypad row scan, release detection, result register and stream ports
// an accepted transaction's result reaches the master side in the next cycle
// throughput: one transaction per cycle while results are taken; all work is one pass
//   of logic into state and result registers; the result register frees as it is taken
// reset: synchronous active low; clears key mask, scan row, stack fill and result valid;
//   stack entries are not cleared
`timescale 1ns / 1ps

module keypad_matrix_scanner_with_event_stack import kms_pkg::*; #(
    parameter int DEPTH = STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] column_bits
    input  logic [7:0]  i_s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] row_drive, [2] popped_valid, [6:3] popped_key, [17:7] pressed_mask,
    // [21:18] single_key, [23:22] single_status, [28:24] event_count
    output logic [31:0] o_m_axis_tdata
);

    localparam int FW = $clog2(DEPTH + 1);

    logic [KEY_COUNT-1:0] r_mask;
    logic [KEY_COUNT-1:0] n_mask;
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     n_row;
    logic                 r_out_valid;
    logic [31:0]          r_out_data;
    logic [31:0]          n_out_data;

    logic                 accept;
    logic [1:0]           func;
    logic [COL_COUNT-1:0] cols;
    logic                 is_scan;
    t_map_ent             ent;
    t_stack_cmd           cmd;
    logic                 pop_valid;
    t_key                 pop_key;
    logic [FW-1:0]        fill_next;
    logic [31:0]          fill_wide;
    logic [KEY_COUNT-1:0] mask_m1;
    logic [1:0]           status;
    t_key                 single;

    // column order 0, 2, 1 gives ascending key order in every row
    localparam logic [COL_COUNT-1:0][1:0] COL_ORDER = {2'd1, 2'd2, 2'd0};

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign func            = i_s_axis_tuser;
    assign cols            = i_s_axis_tdata[COL_COUNT-1:0];
    assign is_scan         = (func == FUNC_SCAN);

    // row update and release detection
    always_comb begin
        n_mask       = r_mask;
        n_row        = r_row;
        cmd.en       = accept;
        cmd.pop      = (func == FUNC_POP);
        cmd.clear    = (func == FUNC_CLEAR);
        cmd.push_vld = '0;
        cmd.push_key = '0;
        ent          = '0;
        if (is_scan) begin
            for (int j = 0; j < COL_COUNT; j++) begin
                ent = key_at(r_row, COL_ORDER[j]);
                if (ent.vld) begin
                    n_mask[ent.key]  = cols[COL_ORDER[j]];
                    cmd.push_vld[j]  = r_mask[ent.key] && !cols[COL_ORDER[j]];
                    cmd.push_key[j]  = ent.key;
                end
            end
            n_row = r_row + ROW_W'(1);
        end
    end

    kms_stack #(
        .DEPTH (DEPTH),
        .FW    (FW)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_pop_valid (pop_valid),
        .o_pop_key   (pop_key),
        .o_fill_next (fill_next)
    );

    // single-key decode on the updated mask
    assign mask_m1 = n_mask - KEY_COUNT'(1);
    always_comb begin
        single = '0;
        if (n_mask == '0) begin
            status = ST_NONE;
        end else if ((n_mask & mask_m1) != '0) begin
            status = ST_MANY;
        end else begin
            status = ST_ONE;
            for (int i = KEY_COUNT - 1; i >= 0; i--) begin
                if (n_mask[i]) begin
                    single = t_key'(i);
                end
            end
        end
    end

    // result packing
    assign fill_wide = 32'(fill_next);
    always_comb begin
        n_out_data        = '0;
        n_out_data[1:0]   = n_row;
        n_out_data[2]     = pop_valid;
        n_out_data[6:3]   = pop_key;
        n_out_data[17:7]  = n_mask;
        n_out_data[21:18] = single;
        n_out_data[23:22] = status;
        n_out_data[28:24] = fill_wide[4:0];
    end

    // keypad state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_row  <= '0;
        end else if (accept) begin
            r_mask <= n_mask;
            r_row  <= n_row;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: verif/keypad_event_checker.sv
// checker for the keypad scanner: predicts each result and compares it on the master side
`timescale 1ns / 1ps

module keypad_event_checker import kms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    // [2:0] column_bits
    input  logic [7:0]  i_in_data,
    // [1:0] func
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    // [1:0] row_drive, [2] popped_valid, [6:3] popped_key, [17:7] pressed_mask,
    // [21:18] single_key, [23:22] single_status, [28:24] event_count
    input  logic [31:0] i_out_data,
    output int          o_fail_count,
    output int          o_result_count
);

    localparam logic [3:0] NO_KEY     = 4'hf;
    localparam int         REPORT_W   = 29;
    localparam int         MAX_REPORT = 10;

    // one result transaction, msb first, same layout as the master tdata
    typedef struct packed {
        logic [4:0]  event_count;
        logic [1:0]  single_status;
        logic [3:0]  single_key;
        logic [10:0] pressed_mask;
        logic [3:0]  popped_key;
        logic        popped_valid;
        logic [1:0]  row_drive;
    } t_keypad_report;

    // predicted scanner state
    logic [KEY_COUNT-1:0] pressed_keys = '0;
    logic [ROW_W-1:0]     active_row   = '0;
    logic [3:0]           release_lifo [STACK_DEPTH];
    int                   lifo_fill    = 0;

    t_keypad_report expected_reports [$];
    int failures  = 0;
    int results   = 0;

    // keys wired to column 2, column 1, column 0 of a row; NO_KEY marks a missing key
    function automatic logic [11:0] keys_on_row(input logic [ROW_W-1:0] row);
        case (row)
            2'd0:    return {4'd8, 4'd9, 4'd7};
            2'd1:    return {4'd5, 4'd6, 4'd4};
            2'd2:    return {4'd2, 4'd3, 4'd1};
            default: return {4'd0, 4'd10, NO_KEY};
        endcase
    endfunction

    // release push; a full stack loses its oldest entry
    task automatic push_release(input logic [3:0] key);
        if (lifo_fill < STACK_DEPTH) begin
            release_lifo[lifo_fill] = key;
            lifo_fill++;
        end else begin
            for (int i = 0; i < STACK_DEPTH - 1; i++)
                release_lifo[i] = release_lifo[i + 1];
            release_lifo[STACK_DEPTH - 1] = key;
        end
    endtask

    // advance the predicted state by one input transaction and build its report
    task automatic predict_keypad_step(input logic [1:0] fn, input logic [2:0] cols,
                                       output t_keypad_report rep);
        logic [11:0]          row_map;
        logic [3:0]           key;
        logic [KEY_COUNT-1:0] next_keys;
        rep = '0;
        if (fn == FUNC_SCAN) begin
            row_map   = keys_on_row(active_row);
            next_keys = pressed_keys;
            for (int c = 0; c < COL_COUNT; c++) begin
                key = row_map[c*4 +: 4];
                if (key != NO_KEY)
                    next_keys[key] = cols[c];
            end
            // falling bits are releases, pushed lowest key first
            for (int i = 0; i < KEY_COUNT; i++)
                if (pressed_keys[i] && !next_keys[i])
                    push_release(4'(i));
            pressed_keys = next_keys;
            active_row   = active_row + ROW_W'(1);
        end else if (fn == FUNC_POP) begin
            if (lifo_fill > 0) begin
                lifo_fill--;
                rep.popped_valid = 1'b1;
                rep.popped_key   = release_lifo[lifo_fill];
            end
        end else if (fn == FUNC_CLEAR) begin
            lifo_fill = 0;
        end

        // single-key decode
        if (pressed_keys == '0) begin
            rep.single_status = ST_NONE;
        end else if ($countones(pressed_keys) > 1) begin
            rep.single_status = ST_MANY;
        end else begin
            rep.single_status = ST_ONE;
            for (int i = KEY_COUNT - 1; i >= 0; i--)
                if (pressed_keys[i])
                    rep.single_key = 4'(i);
        end
        rep.row_drive    = active_row;
        rep.pressed_mask = pressed_keys;
        rep.event_count  = 5'(lifo_fill);
    endtask

    // result side first, then the input side, since each result is registered and trails its input
    always @(posedge i_clk) begin
        t_keypad_report got;
        t_keypad_report want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                results++;
                got = t_keypad_report'(i_out_data[REPORT_W-1:0]);
                if (expected_reports.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORT)
                        $display("%0t: unexpected result transaction %h", $realtime,
                                 i_out_data);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.row_drive     !== want.row_drive     ||
                        got.popped_valid  !== want.popped_valid  ||
                        got.popped_key    !== want.popped_key    ||
                        got.pressed_mask  !== want.pressed_mask  ||
                        got.single_key    !== want.single_key    ||
                        got.single_status !== want.single_status ||
                        got.event_count   !== want.event_count) begin
                        failures++;
                        if (failures <= MAX_REPORT) begin
                            $display("%0t: mismatch expected row %0d pop %0d/%0d mask %h",
                                     $realtime, want.row_drive, want.popped_valid,
                                     want.popped_key, want.pressed_mask,
                                     " single %0d/%0d count %0d",
                                     want.single_key, want.single_status, want.event_count);
                            $display("%0t:          actual   row %0d pop %0d/%0d mask %h",
                                     $realtime, got.row_drive, got.popped_valid,
                                     got.popped_key, got.pressed_mask,
                                     " single %0d/%0d count %0d",
                                     got.single_key, got.single_status, got.event_count);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_keypad_step(i_in_user, i_in_data[2:0], want);
                expected_reports.push_back(want);
            end
        end
        o_fail_count   <= failures;
        o_result_count <= results;
    end

endmodule

FILE: verif/testbench.sv
// testbench top: clock, reset, stimulus, result-side backpressure and verdict
`timescale 1ns / 1ps

module testbench;
    import kms_pkg::*;

    localparam int          CLK_PERIOD     = 12;
    localparam int          RESET_CYCLES   = 6;
    localparam int          RANDOM_ITEMS   = 1725;
    localparam int          MAX_GAP        = 18;
    localparam int          LONG_HOLD      = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [1:0]  FUNC_IGNORED   = 2'd3;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [2:0] column_bits
    logic [7:0]  i_s_axis_tdata  = '0;
    // [1:0] func
    logic [1:0]  i_s_axis_tuser  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [1:0] row_drive, [2] popped_valid, [6:3] popped_key, [17:7] pressed_mask,
    // [21:18] single_key, [23:22] single_status, [28:24] event_count
    logic [31:0] o_m_axis_tdata;

    int fail_count;
    int result_count;
    int sent_count   = 0;
    int idle_cycles  = 0;
    bit tx_fast      = 1'b0;
    bit hold_request = 1'b0;

    keypad_matrix_scanner_with_event_stack dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    keypad_event_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .i_in_ready     (o_s_axis_tready),
        .i_in_data      (i_s_axis_tdata),
        .i_in_user      (i_s_axis_tuser),
        .i_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .i_out_data     (o_m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_result_count (result_count)
    );

    // clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // one input transaction after a random gap; tvalid stays high for back-to-back items
    task automatic send_item(input logic [1:0] fn, input logic [2:0] cols);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= fn;
        i_s_axis_tdata  <= {5'd0, cols};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_count++;
    endtask

    // four scans in a row, one per keypad row
    task automatic scan_sweep(input logic [2:0] cols);
        repeat (ROW_W * 2) send_item(FUNC_SCAN, cols);
    endtask

    // stimulus and verdict
    initial begin
        int          issued;
        int          choice;
        int          density;
        int          mode_start;
        bit          paused;
        logic [2:0]  cols;

        issued     = 0;
        mode_start = 0;
        paused     = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty stack, ignored selector, full press and release, overflow
        send_item(FUNC_POP, 3'b111);
        send_item(FUNC_IGNORED, 3'b101);
        send_item(FUNC_CLEAR, 3'b010);
        scan_sweep(3'b111);
        scan_sweep(3'b000);
        send_item(FUNC_POP, 3'b000);
        scan_sweep(3'b111);
        scan_sweep(3'b000);
        send_item(FUNC_SCAN, 3'b001);
        send_item(FUNC_SCAN, 3'b100);
        send_item(FUNC_POP, 3'b000);
        send_item(FUNC_CLEAR, 3'b000);
        send_item(FUNC_POP, 3'b000);

        // random: mostly row sweeps with random key patterns, plus pops and noise
        while (issued < RANDOM_ITEMS) begin
            if (issued - mode_start >= 150) begin
                tx_fast    = ($urandom_range(0, 2) == 0);
                mode_start = issued;
            end
            if (!hold_request && issued >= 400)
                hold_request = 1'b1;
            if (!paused && issued >= 900) begin
                // let every outstanding result drain before going on
                i_s_axis_tvalid <= 1'b0;
                wait (result_count == sent_count);
                paused = 1'b1;
            end
            choice = $urandom_range(0, 99);
            if (choice < 55) begin
                density = $urandom_range(0, 3);
                repeat (4) begin
                    case (density)
                        0: cols = 3'b000;
                        1: cols = ($urandom_range(0, 3) == 0) ?
                                  3'(1 << $urandom_range(0, 2)) : 3'b000;
                        2: cols = 3'($urandom_range(0, 7));
                        default: cols = 3'b111;
                    endcase
                    send_item(FUNC_SCAN, cols);
                end
                issued += 4;
            end else if (choice < 75) begin
                repeat ($urandom_range(1, 8)) begin
                    send_item(FUNC_POP, 3'($urandom_range(0, 7)));
                    issued++;
                end
            end else if (choice < 85) begin
                send_item(FUNC_SCAN, 3'($urandom_range(0, 7)));
                issued++;
            end else if (choice < 91) begin
                send_item(FUNC_CLEAR, 3'($urandom_range(0, 7)));
                issued++;
            end else if (choice < 95) begin
                send_item(FUNC_IGNORED, 3'($urandom_range(0, 7)));
                issued++;
            end else begin
                // every key down then every key up: eleven releases over one sweep
                scan_sweep(3'b111);
                scan_sweep(3'b000);
                issued += 8;
            end
        end

        i_s_axis_tvalid <= 1'b0;
        wait (result_count == sent_count);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS keypad_matrix_scanner_with_event_stack");
        end else begin
            $display("FAIL keypad_matrix_scanner_with_event_stack");
        end
        $finish;
    end

    // result side: random stalls, idle-free stretches and one long hold-off
    initial begin
        int stall;
        int served;
        bit rx_fast;
        bit hold_done;

        served    = 0;
        rx_fast   = 1'b0;
        hold_done = 1'b0;
        forever begin
            if (served % 200 == 0)
                rx_fast = ($urandom_range(0, 2) == 0);
            if (hold_request && !hold_done) begin
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end
            stall = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            served++;
        end
    end

    // watchdog on cycles without any transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL keypad_matrix_scanner_with_event_stack");
            $finish;
        end
    end

endmodule
